// ===== rtl/bhc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the BMP header check and RGB565 pixel stream.
// No dependencies; every other file of the block but bhc_ifs imports this package.
package bhc_pkg;

    localparam int unsigned POS_W  = 32;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned DIM_W  = 16;
    localparam int unsigned CFG_W  = 16;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [DIM_W-1:0]  dim_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_SKIP,
        PH_PIXEL
    } phase_t;

    typedef enum logic [1:0] {
        LANE_BLUE,
        LANE_GREEN,
        LANE_RED
    } lane_t;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_PIXEL  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CAUSE_NONE       = 3'd0,
        CAUSE_MAGIC      = 3'd1,
        CAUSE_SIZE       = 3'd2,
        CAUSE_PLANES     = 3'd3,
        CAUSE_COMPRESSED = 3'd4
    } cause_t;

    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_REJECT,
        OP_BLUE,
        OP_GREEN,
        OP_RED
    } op_t;

    // Command passed from the parser to the pixel packer through the queue.
    typedef struct packed {
        op_t        op;
        cause_t     cause;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic {
        CFG_DISPLAY_WIDTH  = 1'b0,
        CFG_DISPLAY_HEIGHT = 1'b1
    } cfg_index_t;

    localparam dim_t  DISPLAY_WIDTH_RESET  = 16'd320;
    localparam dim_t  DISPLAY_HEIGHT_RESET = 16'd240;
    localparam logic [15:0] BMP_MAGIC  = 16'h4D42;
    localparam logic [15:0] PLANES_ONE = 16'd1;
    localparam word_t HEADER_LEN = 32'd34;

    // Position of the last byte of each header field that is checked or kept.
    localparam pos_t POS_MAGIC_END  = 32'd1;
    localparam pos_t POS_OFFSET_END = 32'd13;
    localparam pos_t POS_WIDTH_END  = 32'd21;
    localparam pos_t POS_HEIGHT_END = 32'd25;
    localparam pos_t POS_PLANES_END = 32'd27;
    localparam pos_t POS_COMP_END   = 32'd33;

endpackage

// ===== rtl/bhc_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the file bytes and the result items.
// Depends on nothing; the field widths are fixed by the block.
interface bhc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface bhc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [2:0]  reject_cause;
    logic [15:0] pixel_rgb565;

    modport source (output valid, output result_kind, output reject_cause,
                    output pixel_rgb565, input ready);
    modport sink   (input valid, input result_kind, input reject_cause,
                    input pixel_rgb565, output ready);
endinterface

// ===== rtl/bmp_header_check_rgb565_stream.sv =====
`timescale 1ns / 1ps
// Takes a BMP file one byte per cycle and yields one result per header
// decision (accept, or reject with its cause) and one RGB565 pixel per
// blue-green-red triple. Bytes are taken at a sustained rate of one per
// clock while the result side keeps up; the parser and the pixel packer are
// parted by a command queue of QUEUE_DEPTH entries ahead of a registered
// result stage. The size check accepts either orientation of the display
// set in the two configuration registers, which the user must write only
// while the block holds no pending work; the block does not enforce this.
// Depends on bhc_pkg, bhc_ifs, bhc_front, bhc_queue and bhc_back.
module bmp_header_check_rgb565_stream #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    bhc_in_if.sink      bytes,
    bhc_out_if.source   results
);
    import bhc_pkg::*;

    logic queue_full;
    logic queue_empty;
    logic push_valid;
    logic pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    bhc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .bytes      (bytes),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    bhc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    bhc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .results     (results)
    );

endmodule

// ===== rtl/bhc_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts file bytes, parses and checks the BMP header, counts
// off the gap to the pixel data and tags pixel bytes. Uses bhc_pkg, bhc_ifs.
module bhc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data,
    bhc_in_if.sink               bytes,
    input  logic                 queue_full,
    output logic                 push_valid,
    output bhc_pkg::cmd_t        push_cmd
);
    import bhc_pkg::*;

    phase_t phase_reg, phase_next;
    pos_t   pos_reg, pos_next;
    lane_t  lane_reg, lane_next;
    word_t  shift_reg, shift_next;
    word_t  offset_reg, offset_next;
    word_t  width_reg, width_next;
    dim_t   disp_w_reg, disp_h_reg;

    logic   in_fire;
    phase_t cur_phase;
    pos_t   cur_pos;
    lane_t  cur_lane;
    word_t  shift_new;
    dim_t   disp_max, disp_min;
    word_t  img_max, img_min;
    logic   size_ok;
    logic   magic_ok;
    logic   planes_ok;
    logic   comp_ok;

    assign bytes.ready = !queue_full;
    assign in_fire     = bytes.valid && !queue_full;

    // A first byte restarts the parse whatever state the previous file left.
    assign cur_phase = bytes.first_byte ? PH_HEADER : phase_reg;
    assign cur_pos   = bytes.first_byte ? '0 : pos_reg;
    assign cur_lane  = bytes.first_byte ? LANE_BLUE : lane_reg;
    assign shift_new = {bytes.data_byte, shift_reg[WORD_W-1:8]};

    assign disp_max  = (disp_w_reg > disp_h_reg) ? disp_w_reg : disp_h_reg;
    assign disp_min  = (disp_w_reg > disp_h_reg) ? disp_h_reg : disp_w_reg;
    assign img_max   = (width_reg > shift_new) ? width_reg : shift_new;
    assign img_min   = (width_reg > shift_new) ? shift_new : width_reg;
    assign size_ok   = (img_max == {{(WORD_W-DIM_W){1'b0}}, disp_max})
                    && (img_min == {{(WORD_W-DIM_W){1'b0}}, disp_min});
    assign magic_ok  = (shift_new[31:16] == BMP_MAGIC);
    assign planes_ok = (shift_new[31:16] == PLANES_ONE);
    assign comp_ok   = (shift_new == '0);

    always_comb
    begin
        phase_next = phase_reg;
        if (in_fire)
        begin
            phase_next = cur_phase;
            case (cur_phase)
                PH_HEADER:
                begin
                    case (cur_pos)
                        POS_MAGIC_END:  if (!magic_ok)  phase_next = PH_IDLE;
                        POS_HEIGHT_END: if (!size_ok)   phase_next = PH_IDLE;
                        POS_PLANES_END: if (!planes_ok) phase_next = PH_IDLE;
                        POS_COMP_END:
                        begin
                            if (!comp_ok)
                                phase_next = PH_IDLE;
                            else if (offset_reg <= HEADER_LEN)
                                phase_next = PH_PIXEL;
                            else
                                phase_next = PH_SKIP;
                        end
                        default: phase_next = PH_HEADER;
                    endcase
                end
                PH_SKIP:
                begin
                    if (cur_pos == offset_reg)
                        phase_next = PH_PIXEL;
                end
                default: phase_next = cur_phase;
            endcase
        end
    end

    always_comb
    begin
        logic pixel_byte;
        pixel_byte  = 1'b0;
        pos_next    = pos_reg;
        lane_next   = lane_reg;
        shift_next  = shift_reg;
        offset_next = offset_reg;
        width_next  = width_reg;
        push_valid  = 1'b0;
        push_cmd    = '{op: OP_ACCEPT, cause: CAUSE_NONE, data: bytes.data_byte};
        if (in_fire)
        begin
            pos_next  = cur_pos;
            lane_next = cur_lane;
            case (cur_phase)
                PH_HEADER:
                begin
                    shift_next = shift_new;
                    pos_next   = cur_pos + 1'b1;
                    case (cur_pos)
                        POS_MAGIC_END:
                        begin
                            if (!magic_ok)
                            begin
                                push_valid     = 1'b1;
                                push_cmd.op    = OP_REJECT;
                                push_cmd.cause = CAUSE_MAGIC;
                            end
                        end
                        POS_OFFSET_END: offset_next = shift_new;
                        POS_WIDTH_END:  width_next  = shift_new;
                        POS_HEIGHT_END:
                        begin
                            if (!size_ok)
                            begin
                                push_valid     = 1'b1;
                                push_cmd.op    = OP_REJECT;
                                push_cmd.cause = CAUSE_SIZE;
                            end
                        end
                        POS_PLANES_END:
                        begin
                            if (!planes_ok)
                            begin
                                push_valid     = 1'b1;
                                push_cmd.op    = OP_REJECT;
                                push_cmd.cause = CAUSE_PLANES;
                            end
                        end
                        POS_COMP_END:
                        begin
                            push_valid = 1'b1;
                            lane_next  = LANE_BLUE;
                            if (!comp_ok)
                            begin
                                push_cmd.op    = OP_REJECT;
                                push_cmd.cause = CAUSE_COMPRESSED;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_SKIP:
                begin
                    if (cur_pos != offset_reg)
                        pos_next = cur_pos + 1'b1;
                    else
                        pixel_byte = 1'b1;
                end
                PH_PIXEL: pixel_byte = 1'b1;
                default: ;
            endcase

            if (pixel_byte)
            begin
                push_valid = 1'b1;
                case (cur_lane)
                    LANE_BLUE:
                    begin
                        push_cmd.op = OP_BLUE;
                        lane_next   = LANE_GREEN;
                    end
                    LANE_GREEN:
                    begin
                        push_cmd.op = OP_GREEN;
                        lane_next   = LANE_RED;
                    end
                    default:
                    begin
                        push_cmd.op = OP_RED;
                        lane_next   = LANE_BLUE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            lane_reg   <= LANE_BLUE;
            disp_w_reg <= DISPLAY_WIDTH_RESET;
            disp_h_reg <= DISPLAY_HEIGHT_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            lane_reg  <= lane_next;
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_DISPLAY_WIDTH:  disp_w_reg <= cfg_data[DIM_W-1:0];
                    CFG_DISPLAY_HEIGHT: disp_h_reg <= cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg  <= shift_next;
        offset_reg <= offset_next;
        width_reg  <= width_next;
    end

endmodule

// ===== rtl/bhc_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the header parser and the pixel packer.
// Uses bhc_pkg for the command type.
module bhc_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bhc_pkg::cmd_t push_cmd,
    input  logic          pop,
    output bhc_pkg::cmd_t head_cmd,
    output logic          full,
    output logic          empty
);
    import bhc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/bhc_back.sv =====
`timescale 1ns / 1ps
// Back end: packs tagged blue, green and red bytes into RGB565 pixels and
// drives the registered result channel. Uses bhc_pkg and bhc_ifs.
module bhc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          queue_empty,
    input  bhc_pkg::cmd_t head_cmd,
    output logic          pop,
    bhc_out_if.source     results
);
    import bhc_pkg::*;

    logic        out_valid_reg, out_valid_next;
    kind_t       kind_reg, kind_next;
    cause_t      cause_reg, cause_next;
    logic [15:0] pix_reg, pix_next;
    logic [15:0] hold_reg, hold_next;
    logic        slot_free;
    logic        makes_result;

    assign slot_free    = !out_valid_reg || results.ready;
    // Blue and green bytes only update the partial pixel and never wait.
    assign makes_result = (head_cmd.op != OP_BLUE) && (head_cmd.op != OP_GREEN);
    assign pop          = !queue_empty && (slot_free || !makes_result);

    always_comb
    begin
        out_valid_next = out_valid_reg && !results.ready;
        kind_next      = kind_reg;
        cause_next     = cause_reg;
        pix_next       = pix_reg;
        hold_next      = hold_reg;
        if (pop)
        begin
            case (head_cmd.op)
                OP_BLUE:  hold_next = {11'b0, head_cmd.data[7:3]};
                OP_GREEN: hold_next = hold_reg | {5'b0, head_cmd.data[7:2], 5'b0};
                OP_RED:
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_PIXEL;
                    cause_next     = CAUSE_NONE;
                    pix_next       = hold_reg | {head_cmd.data[7:3], 11'b0};
                end
                OP_REJECT:
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_REJECT;
                    cause_next     = head_cmd.cause;
                    pix_next       = '0;
                end
                default:
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ACCEPT;
                    cause_next     = CAUSE_NONE;
                    pix_next       = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        cause_reg <= cause_next;
        pix_reg   <= pix_next;
        hold_reg  <= hold_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.result_kind  = kind_reg;
    assign results.reject_cause = cause_reg;
    assign results.pixel_rgb565 = pix_reg;

endmodule
